@@ src/pcc_pkg.sv @@
// ----------------------------------------------------------------------------
// pcc_pkg
// Shared types, codes and constants of the pulse channel control block.
// ----------------------------------------------------------------------------
package pcc_pkg;

  typedef enum logic [1:0] {
    OP_REG_WRITE    = 2'd0,
    OP_QUARTER_TICK = 2'd1,
    OP_HALF_TICK    = 2'd2,
    OP_ENABLE_WRITE = 2'd3
  } op_t;

  localparam logic [1:0] REG_CTRL      = 2'd0;
  localparam logic [1:0] REG_SWEEP     = 2'd1;
  localparam logic [1:0] REG_PERIOD_LO = 2'd2;
  localparam logic [1:0] REG_PERIOD_HI = 2'd3;

  localparam logic [11:0] PERIOD_MIN = 12'd8;
  localparam logic [11:0] PERIOD_MAX = 12'h7ff;
  localparam logic [3:0]  ENV_MAX    = 4'd15;

  localparam logic [7:0] LEN_TABLE [32] = '{
    8'd10,  8'd254, 8'd20, 8'd2,  8'd40, 8'd4,  8'd80, 8'd6,
    8'd160, 8'd8,   8'd60, 8'd10, 8'd14, 8'd12, 8'd26, 8'd14,
    8'd12,  8'd16,  8'd24, 8'd18, 8'd48, 8'd20, 8'd96, 8'd22,
    8'd192, 8'd24,  8'd72, 8'd26, 8'd16, 8'd28, 8'd32, 8'd30
  };

  typedef struct packed {
    logic [1:0] operation;
    logic [1:0] reg_index;
    logic [7:0] write_value;
  } item_t;

  typedef struct packed {
    logic [3:0][7:0] regs;
    logic            enabled;
    logic            env_restart;
    logic [3:0]      env_div;
    logic [3:0]      env_level;
    logic            sweep_reload;
    logic [2:0]      sweep_div;
    logic [11:0]     period;
    logic [7:0]      length;
  } chan_state_t;

endpackage

@@ src/pulse_channel_control.sv @@
// ----------------------------------------------------------------------------
// pulse_channel_control
// Control logic of one pulse channel: registers, envelope, sweep, length.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one item: a register write,
//   a quarter-frame tick, a half-frame tick or an enable write.
//   Output channel (out_valid/out_ready) returns one result item per input
//   item: timer period, duty, volume, mute flag and length status.
//   cfg_valid/cfg_ready writes negate_extra_one; cfg_ready is always high.
//   Write it only while no item is in flight.
// Timing:
//   An item waits in the input register until the update fires; its result
//   is then written into the output register. One item is accepted per cycle
//   while out_ready does not hold the result; the state update is a single pass
//   of logic between the input and result registers.
// Reset / stall:
//   Synchronous reset clears all channel state and both valid flags.
//   While out_ready is low, the result holds and one more item can wait in
//   the input register; in_ready drops only when both are full.
// ----------------------------------------------------------------------------
module pulse_channel_control (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_negate_extra_one,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [1:0]  in_reg_index,
  input  logic [7:0]  in_write_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] out_timer_period,
  output logic [1:0]  out_duty_select,
  output logic [3:0]  out_volume,
  output logic        out_muted,
  output logic        out_length_active
);

  logic                 negate_extra_one_r;
  logic                 advance;
  logic                 item_valid;
  logic                 fire;
  pcc_pkg::item_t       in_item;
  pcc_pkg::item_t       item;
  pcc_pkg::chan_state_t state_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      negate_extra_one_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      negate_extra_one_r <= cfg_negate_extra_one;
    end
  end

  assign in_item.operation   = in_operation;
  assign in_item.reg_index   = in_reg_index;
  assign in_item.write_value = in_write_value;

  assign advance = !out_valid || out_ready;
  assign fire    = item_valid && advance;

  pcc_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .advance  (advance),
    .valid    (item_valid),
    .item     (item)
  );

  pcc_update u_update (
    .clk              (clk),
    .rst_n            (rst_n),
    .fire             (fire),
    .item             (item),
    .negate_extra_one (negate_extra_one_r),
    .state_nxt        (state_nxt)
  );

  pcc_result u_result (
    .clk               (clk),
    .rst_n             (rst_n),
    .fire              (fire),
    .state_nxt         (state_nxt),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_timer_period  (out_timer_period),
    .out_duty_select   (out_duty_select),
    .out_volume        (out_volume),
    .out_muted         (out_muted),
    .out_length_active (out_length_active)
  );

`ifndef SYNTHESIS
  a_muted_silent : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_muted |-> out_volume == 4'd0)
    else $error("muted result with nonzero volume");

  a_no_length_muted : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_length_active |-> out_muted)
    else $error("zero length count not muted");

  a_audible_period : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_muted |-> out_timer_period >= 12'd8 && out_timer_period <= 12'h7ff)
    else $error("audible result with period out of range");

  a_stall_backpressure : assert property (@(posedge clk) disable iff (!rst_n)
    item_valid && out_valid && !out_ready |-> !in_ready)
    else $error("input accepted while both stages are full");
`endif

endmodule

@@ src/pcc_in_reg.sv @@
// ----------------------------------------------------------------------------
// pcc_in_reg
// Input register: holds one accepted item until the update stage takes it.
// ----------------------------------------------------------------------------
module pcc_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pcc_pkg::item_t    in_item,
  input  logic              advance,
  output logic              valid,
  output pcc_pkg::item_t    item
);

  logic           valid_r;
  pcc_pkg::item_t item_r;

  assign in_ready = !valid_r || advance;
  assign valid    = valid_r;
  assign item     = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

@@ src/pcc_update.sv @@
// ----------------------------------------------------------------------------
// pcc_update
// Channel state registers and the single-pass update for one item.
// ----------------------------------------------------------------------------
module pcc_update (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fire,
  input  pcc_pkg::item_t        item,
  input  logic                  negate_extra_one,
  output pcc_pkg::chan_state_t  state_nxt
);

  pcc_pkg::chan_state_t state_r;

  logic [3:0]  env_div_clk;
  logic [3:0]  env_level_clk;
  logic [2:0]  shift;
  logic [11:0] delta;
  logic        sweep_go;
  logic [11:0] swept;

  // Envelope clock, shared by both tick kinds
  always_comb begin
    env_div_clk   = state_r.env_div;
    env_level_clk = state_r.env_level;
    if (state_r.env_restart) begin
      env_div_clk   = state_r.regs[pcc_pkg::REG_CTRL][3:0];
      env_level_clk = pcc_pkg::ENV_MAX;
    end else if (state_r.env_div == 4'd0) begin
      env_div_clk = state_r.regs[pcc_pkg::REG_CTRL][3:0];
      if (state_r.env_level != 4'd0) begin
        env_level_clk = state_r.env_level - 4'd1;
      end else if (state_r.regs[pcc_pkg::REG_CTRL][5]) begin
        env_level_clk = pcc_pkg::ENV_MAX;
      end
    end else begin
      env_div_clk = state_r.env_div - 4'd1;
    end
  end

  // Sweep period adjust
  always_comb begin
    shift    = state_r.regs[pcc_pkg::REG_SWEEP][2:0];
    delta    = state_r.period >> shift;
    sweep_go = (state_r.sweep_div == 3'd0) && state_r.regs[pcc_pkg::REG_SWEEP][7] &&
               (shift != 3'd0) && (state_r.period >= pcc_pkg::PERIOD_MIN) &&
               (state_r.period <= pcc_pkg::PERIOD_MAX);
    if (state_r.regs[pcc_pkg::REG_SWEEP][3]) begin
      swept = state_r.period - delta - {11'd0, negate_extra_one};
    end else begin
      swept = state_r.period + delta;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (pcc_pkg::op_t'(item.operation))
      pcc_pkg::OP_REG_WRITE: begin
        state_nxt.regs[item.reg_index] = item.write_value;
        case (item.reg_index)
          pcc_pkg::REG_SWEEP: begin
            state_nxt.sweep_reload = 1'b1;
          end
          pcc_pkg::REG_PERIOD_LO: begin
            state_nxt.period = {1'b0, state_r.regs[pcc_pkg::REG_PERIOD_HI][2:0],
                                item.write_value};
          end
          pcc_pkg::REG_PERIOD_HI: begin
            state_nxt.period      = {1'b0, item.write_value[2:0],
                                     state_r.regs[pcc_pkg::REG_PERIOD_LO]};
            state_nxt.env_restart = 1'b1;
            if (state_r.enabled) begin
              state_nxt.length = pcc_pkg::LEN_TABLE[item.write_value[7:3]];
            end
          end
          default: begin
          end
        endcase
      end
      pcc_pkg::OP_QUARTER_TICK: begin
        state_nxt.env_restart = 1'b0;
        state_nxt.env_div     = env_div_clk;
        state_nxt.env_level   = env_level_clk;
      end
      pcc_pkg::OP_HALF_TICK: begin
        if (!state_r.regs[pcc_pkg::REG_CTRL][5] && state_r.length != 8'd0) begin
          state_nxt.length = state_r.length - 8'd1;
        end
        if (sweep_go) begin
          state_nxt.period = swept;
        end
        if (state_r.sweep_reload || state_r.sweep_div == 3'd0) begin
          state_nxt.sweep_reload = 1'b0;
          state_nxt.sweep_div    = state_r.regs[pcc_pkg::REG_SWEEP][6:4];
        end else begin
          state_nxt.sweep_div = state_r.sweep_div - 3'd1;
        end
        state_nxt.env_restart = 1'b0;
        state_nxt.env_div     = env_div_clk;
        state_nxt.env_level   = env_level_clk;
      end
      pcc_pkg::OP_ENABLE_WRITE: begin
        state_nxt.enabled = item.write_value[0];
        if (!item.write_value[0]) begin
          state_nxt.length = 8'd0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (fire) begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ src/pcc_result.sv @@
// ----------------------------------------------------------------------------
// pcc_result
// Mute and volume decode of the updated state, and the result register.
// ----------------------------------------------------------------------------
module pcc_result (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fire,
  input  pcc_pkg::chan_state_t  state_nxt,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [11:0]           out_timer_period,
  output logic [1:0]            out_duty_select,
  output logic [3:0]            out_volume,
  output logic                  out_muted,
  output logic                  out_length_active
);

  logic        valid_r;
  logic [11:0] period_r;
  logic [1:0]  duty_r;
  logic [3:0]  volume_r;
  logic        muted_r;
  logic        active_r;

  logic        muted_nxt;
  logic [3:0]  volume_nxt;

  always_comb begin
    muted_nxt = !state_nxt.enabled || (state_nxt.length == 8'd0) ||
                (state_nxt.period < pcc_pkg::PERIOD_MIN) ||
                (state_nxt.period > pcc_pkg::PERIOD_MAX);
    if (muted_nxt) begin
      volume_nxt = 4'd0;
    end else if (state_nxt.regs[pcc_pkg::REG_CTRL][4]) begin
      volume_nxt = state_nxt.regs[pcc_pkg::REG_CTRL][3:0];
    end else begin
      volume_nxt = state_nxt.env_level;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (fire) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      period_r <= state_nxt.period;
      duty_r   <= state_nxt.regs[pcc_pkg::REG_CTRL][7:6];
      volume_r <= volume_nxt;
      muted_r  <= muted_nxt;
      active_r <= (state_nxt.length != 8'd0);
    end
  end

  assign out_valid         = valid_r;
  assign out_timer_period  = period_r;
  assign out_duty_select   = duty_r;
  assign out_volume        = volume_r;
  assign out_muted         = muted_r;
  assign out_length_active = active_r;

endmodule
